[sv/tsfs_pkg.sv]
// Shared types, constants and helpers of the transport stream frame sync detector.
// Used by every module of the block; depends on nothing else.

package tsfs_pkg;

  // Default frame geometry.
  localparam int unsigned PACKET_BYTES_DEF      = 204;
  localparam int unsigned PACKETS_PER_FRAME_DEF = 8;

  // Fixed field widths.
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned SHIFT_W = 3;
  localparam int unsigned ERR_W   = 7;
  localparam int unsigned LANES   = 2 ** SHIFT_W;

  // Sync byte patterns and the polarity flip mask.
  localparam logic [7:0] SYNC_FIRST = 8'hB8;
  localparam logic [7:0] SYNC_REST  = 8'h47;
  localparam logic [7:0] INV_MASK   = 8'hFF;

  localparam logic [ERR_W-1:0] MAX_ERR_RESET = 7'd8;

  // Register index decoded from the configuration address.
  localparam logic REG_MAX_SYNC_ERRORS = 1'b0;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Command handed from the front end to the back end.
  typedef struct packed {
    op_e                op;
    logic               in_range;
    logic [7:0]         data_byte;
    logic [IDX_W-1:0]   read_index;
    logic [SHIFT_W-1:0] read_shift;
    logic               read_inverted;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic               is_read_data;
    logic [SHIFT_W-1:0] bit_shift;
    logic               inverted;
    logic [7:0]         frame_byte;
    logic               last;
  } res_t;

  // Number of set bits in a byte.
  function automatic logic [3:0] bit_count8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'b000, v[k]};
    end
    return n;
  endfunction

endpackage

[sv/ts_frame_sync_detector.sv]
// Top level of the transport stream frame sync detector: configuration register,
// front end, byte window, back end and result queue. Depends on tsfs_pkg.
//
// Input channel (push/full): operation 0 shifts data_byte into a window of
// PACKET_BYTES*PACKETS_PER_FRAME+1 bytes and scores all eight bit offsets against
// the sync pattern (0xB8 then 0x47, or its inverse); each offset within
// max_sync_errors yields one notice, lowest offset first, the final one marked last.
// Operation 1 returns one realigned, optionally inverted window byte.
// Result channel (empty/pop): queue semantics, the oldest result is on the ports.
// Notices of a push leave one per cycle while the result queue has space. A push
// holds the issue stage for a pass over the sync byte pairs, one pair per packet,
// through the two read ports of the window memory, so the next transaction waits
// until that pass is done; reads are taken one per cycle while the back end is not
// held. Reset clears all queues and sets max_sync_errors to 8; the window reads
// as all zero through a fill count, so no clearing pass is needed. When the
// receiver stalls, the result queue fills, the back end holds and the input
// queue raises full.

module ts_frame_sync_detector import tsfs_pkg::*; #(
  parameter int unsigned PACKET_BYTES      = PACKET_BYTES_DEF,
  parameter int unsigned PACKETS_PER_FRAME = PACKETS_PER_FRAME_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic               operation_i,
  input  logic [7:0]         data_byte_i,
  input  logic [IDX_W-1:0]   read_index_i,
  input  logic [SHIFT_W-1:0] read_shift_i,
  input  logic               read_inverted_i,
  output logic               empty,
  input  logic               pop,
  output logic               is_read_data_o,
  output logic [SHIFT_W-1:0] bit_shift_o,
  output logic               inverted_o,
  output logic [7:0]         frame_byte_o,
  output logic               last_o
);

  localparam int unsigned PosW = $clog2(PACKET_BYTES * PACKETS_PER_FRAME + 1);

  logic [ERR_W-1:0] max_err_q;
  logic             cfg_write;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  logic             win_wr_en, win_rd_en;
  logic [7:0]       win_wr_data, win_rd_data_a, win_rd_data_b;
  logic [PosW-1:0]  win_rd_pos_a, win_rd_pos_b;
  logic             res_full, res_write;
  res_t             res_in, res_out;

  // Configuration register access.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_SYNC_ERRORS);
  assign prdata    = (paddr[2] == REG_MAX_SYNC_ERRORS) ? 32'(max_err_q) : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_err_q <= MAX_ERR_RESET;
    end else if (cfg_write) begin
      max_err_q <= pwdata[ERR_W-1:0];
    end
  end

  tsfs_front #(
    .PACKET_BYTES      (PACKET_BYTES),
    .PACKETS_PER_FRAME (PACKETS_PER_FRAME)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_push_i       (push),
    .in_full_o       (full),
    .operation_i     (operation_i),
    .data_byte_i     (data_byte_i),
    .read_index_i    (read_index_i),
    .read_shift_i    (read_shift_i),
    .read_inverted_i (read_inverted_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  tsfs_window #(
    .PACKET_BYTES      (PACKET_BYTES),
    .PACKETS_PER_FRAME (PACKETS_PER_FRAME)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (win_wr_en),
    .wr_data_i   (win_wr_data),
    .rd_en_i     (win_rd_en),
    .rd_pos_a_i  (win_rd_pos_a),
    .rd_pos_b_i  (win_rd_pos_b),
    .rd_data_a_o (win_rd_data_a),
    .rd_data_b_o (win_rd_data_b)
  );

  tsfs_back #(
    .PACKET_BYTES      (PACKET_BYTES),
    .PACKETS_PER_FRAME (PACKETS_PER_FRAME)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .max_sync_errors_i (max_err_q),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_pop_o         (cmd_pop),
    .win_wr_en_o       (win_wr_en),
    .win_wr_data_o     (win_wr_data),
    .win_rd_en_o       (win_rd_en),
    .win_rd_pos_a_o    (win_rd_pos_a),
    .win_rd_pos_b_o    (win_rd_pos_b),
    .win_rd_data_a_i   (win_rd_data_a),
    .win_rd_data_b_i   (win_rd_data_b),
    .res_full_i        (res_full),
    .res_write_o       (res_write),
    .res_o             (res_in)
  );

  tsfs_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .write_i (res_write),
    .data_i  (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (res_out)
  );

  assign is_read_data_o = res_out.is_read_data;
  assign bit_shift_o    = res_out.bit_shift;
  assign inverted_o     = res_out.inverted;
  assign frame_byte_o   = res_out.frame_byte;
  assign last_o         = res_out.last;

  // The back end never writes a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_write |-> !res_full)
    else $error("result written while the result queue is full");

  // Commands are only taken when the front queue holds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_valid)
    else $error("command popped from an empty front queue");

  // An accepted input transaction is waiting in the front queue in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (push && !full) |=> cmd_valid)
    else $error("accepted transaction missing from the front queue");

  // A read answer is always the final result of its transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res_write && res_in.is_read_data) |-> res_in.last)
    else $error("read answer without last");

endmodule

[sv/tsfs_front.sv]
// Front end of the frame sync detector: accepts input transactions, classifies them
// and queues commands for the back end. Depends on tsfs_pkg.

module tsfs_front import tsfs_pkg::*; #(
  parameter int unsigned PACKET_BYTES      = PACKET_BYTES_DEF,
  parameter int unsigned PACKETS_PER_FRAME = PACKETS_PER_FRAME_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_push_i,
  output logic               in_full_o,
  input  logic               operation_i,
  input  logic [7:0]         data_byte_i,
  input  logic [IDX_W-1:0]   read_index_i,
  input  logic [SHIFT_W-1:0] read_shift_i,
  input  logic               read_inverted_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_pop_i
);

  localparam int unsigned FrameBytes = PACKET_BYTES * PACKETS_PER_FRAME;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned PtrW       = $clog2(QDepth);
  localparam int unsigned CntW       = $clog2(QDepth + 1);

  cmd_t            cmd_in;
  cmd_t            queue_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en, rd_en;

  // Classify the incoming transaction.
  always_comb begin
    cmd_in               = '0;
    cmd_in.op            = op_e'(operation_i);
    cmd_in.in_range      = (32'(read_index_i) < FrameBytes);
    cmd_in.data_byte     = data_byte_i;
    cmd_in.read_index    = read_index_i;
    cmd_in.read_shift    = read_shift_i;
    cmd_in.read_inverted = read_inverted_i;
  end

  // Queue control.
  assign in_full_o   = (cnt_q == CntW'(QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign wr_en       = in_push_i && !in_full_o;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(wr_en) - CntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Command storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

[sv/tsfs_window.sv]
// Byte window of the frame sync detector: a circular buffer memory with one write
// port and two registered read ports addressed by window position. Depends on tsfs_pkg.

module tsfs_window import tsfs_pkg::*; #(
  parameter int unsigned PACKET_BYTES      = PACKET_BYTES_DEF,
  parameter int unsigned PACKETS_PER_FRAME = PACKETS_PER_FRAME_DEF,
  localparam int unsigned PosW = $clog2(PACKET_BYTES * PACKETS_PER_FRAME + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [7:0]      wr_data_i,
  input  logic            rd_en_i,
  input  logic [PosW-1:0] rd_pos_a_i,
  input  logic [PosW-1:0] rd_pos_b_i,
  output logic [7:0]      rd_data_a_o,
  output logic [7:0]      rd_data_b_o
);

  localparam int unsigned WindowBytes = PACKET_BYTES * PACKETS_PER_FRAME + 1;
  localparam int unsigned Depth       = 2 ** PosW;
  localparam int unsigned FillW       = PosW + 1;

  logic [7:0]       mem [Depth];
  logic [PosW-1:0]  wp_q, wp_eff;
  logic [FillW-1:0] fill_q, fill_eff;
  logic [PosW-1:0]  addr_a, addr_b;
  logic             valid_a, valid_b;
  logic [7:0]       dat_a_q, dat_b_q;
  logic             vld_a_q, vld_b_q;

  // Positions are taken after a write in the same cycle; unwritten entries read as zero.
  always_comb begin
    wp_eff   = wr_en_i ? wp_q + PosW'(1) : wp_q;
    fill_eff = (wr_en_i && (fill_q != FillW'(WindowBytes))) ? fill_q + FillW'(1) : fill_q;
    addr_a   = wp_eff + rd_pos_a_i - PosW'(WindowBytes);
    addr_b   = wp_eff + rd_pos_b_i - PosW'(WindowBytes);
    valid_a  = (({1'b0, rd_pos_a_i} + fill_eff) >= FillW'(WindowBytes));
    valid_b  = (({1'b0, rd_pos_b_i} + fill_eff) >= FillW'(WindowBytes));
  end

  // Write pointer, fill count and read qualifiers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      fill_q  <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      wp_q   <= wp_eff;
      fill_q <= fill_eff;
      if (rd_en_i) begin
        vld_a_q <= valid_a;
        vld_b_q <= valid_b;
      end
    end
  end

  // Memory array with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wp_q] <= wr_data_i;
    end
    if (rd_en_i) begin
      dat_a_q <= mem[addr_a];
      dat_b_q <= mem[addr_b];
    end
  end

  assign rd_data_a_o = vld_a_q ? dat_a_q : 8'h00;
  assign rd_data_b_o = vld_b_q ? dat_b_q : 8'h00;

endmodule

[sv/tsfs_res_fifo.sv]
// Result queue of the frame sync detector: a four-entry register queue that
// separates the back end from the result receiver. Depends on tsfs_pkg.

module tsfs_res_fifo import tsfs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic write_i,
  input  res_t data_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  res_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            wr_en, rd_en;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign wr_en   = write_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(wr_en) - CntW'(rd_en);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[sv/tsfs_back.sv]
// Back end of the frame sync detector: issues window reads, scores all eight bit
// offsets in parallel lanes and emits notices and read answers. Depends on tsfs_pkg.

module tsfs_back import tsfs_pkg::*; #(
  parameter int unsigned PACKET_BYTES      = PACKET_BYTES_DEF,
  parameter int unsigned PACKETS_PER_FRAME = PACKETS_PER_FRAME_DEF,
  localparam int unsigned PosW = $clog2(PACKET_BYTES * PACKETS_PER_FRAME + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ERR_W-1:0] max_sync_errors_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             win_wr_en_o,
  output logic [7:0]       win_wr_data_o,
  output logic             win_rd_en_o,
  output logic [PosW-1:0]  win_rd_pos_a_o,
  output logic [PosW-1:0]  win_rd_pos_b_o,
  input  logic [7:0]       win_rd_data_a_i,
  input  logic [7:0]       win_rd_data_b_i,
  input  logic             res_full_i,
  output logic             res_write_o,
  output res_t             res_o
);

  localparam int unsigned CntW    = (PACKETS_PER_FRAME > 1) ? $clog2(PACKETS_PER_FRAME) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(PACKETS_PER_FRAME - 1);
  localparam logic        OnePacket = (PACKETS_PER_FRAME == 1);

  // Tag that travels with each window read.
  typedef struct packed {
    logic               is_read;
    logic               first;
    logic               last_pkt;
    logic               in_range;
    logic [SHIFT_W-1:0] shift;
    logic               inv;
  } tag_t;

  logic             iss_busy_q, iss_busy_d;
  logic [CntW-1:0]  iss_cnt_q, iss_cnt_d;
  logic [PosW-1:0]  iss_pos_q, iss_pos_d;
  logic [PosW-1:0]  cmd_pos;
  tag_t             tag_q, tag_d;
  logic             tag_vld_q, tag_vld_d;
  logic             stall, d_take;

  logic [ERR_W-1:0] acc_n_q [LANES];
  logic [ERR_W-1:0] acc_i_q [LANES];
  logic [ERR_W-1:0] acc_n_new [LANES];
  logic [ERR_W-1:0] acc_i_new [LANES];
  logic [LANES-1:0] hit_mask, hit_inv;
  logic [15:0]      pair;
  logic [15:0]      pair_shl;
  logic [7:0]       want;

  logic [LANES-1:0]   em_mask_q, em_mask_d;
  logic [LANES-1:0]   em_inv_q, em_inv_d;
  logic               em_busy, em_one, em_emit, em_can_load, res_space;
  logic [SHIFT_W-1:0] em_sel;
  logic               em_found;
  logic               load_mask;
  logic               read_out;

  assign cmd_pos = PosW'(32'(cmd_i.read_index));

  // Issue stage: one window read pair per cycle unless the data stage stalls, a push takes one per packet.
  always_comb begin
    cmd_pop_o      = 1'b0;
    win_wr_en_o    = 1'b0;
    win_wr_data_o  = cmd_i.data_byte;
    win_rd_en_o    = 1'b0;
    win_rd_pos_a_o = '0;
    win_rd_pos_b_o = '0;
    iss_busy_d     = iss_busy_q;
    iss_cnt_d      = iss_cnt_q;
    iss_pos_d      = iss_pos_q;
    tag_d          = tag_q;
    tag_vld_d      = tag_vld_q;
    if (!stall) begin
      tag_d     = '0;
      tag_vld_d = 1'b0;
      if (iss_busy_q) begin
        win_rd_en_o    = 1'b1;
        win_rd_pos_a_o = iss_pos_q;
        win_rd_pos_b_o = iss_pos_q + PosW'(1);
        tag_vld_d      = 1'b1;
        tag_d.last_pkt = (iss_cnt_q == LastCnt);
        iss_cnt_d      = iss_cnt_q + CntW'(1);
        iss_pos_d      = iss_pos_q + PosW'(PACKET_BYTES);
        iss_busy_d     = (iss_cnt_q != LastCnt);
      end else if (cmd_valid_i) begin
        cmd_pop_o   = 1'b1;
        win_rd_en_o = 1'b1;
        tag_vld_d   = 1'b1;
        if (cmd_i.op == OP_READ) begin
          win_rd_pos_a_o = cmd_pos;
          win_rd_pos_b_o = cmd_pos + PosW'(1);
          tag_d.is_read  = 1'b1;
          tag_d.in_range = cmd_i.in_range;
          tag_d.shift    = cmd_i.read_shift;
          tag_d.inv      = cmd_i.read_inverted;
        end else begin
          win_wr_en_o    = 1'b1;
          win_rd_pos_a_o = '0;
          win_rd_pos_b_o = PosW'(1);
          tag_d.first    = 1'b1;
          tag_d.last_pkt = OnePacket;
          iss_busy_d     = !OnePacket;
          iss_cnt_d      = CntW'(1);
          iss_pos_d      = PosW'(PACKET_BYTES);
        end
      end
    end
  end

  // Scoring lanes: error counts of each bit offset against both polarities.
  assign pair = {win_rd_data_a_i, win_rd_data_b_i};
  assign want = tag_q.first ? SYNC_FIRST : SYNC_REST;

  always_comb begin
    for (int s = 0; s < LANES; s++) begin
      acc_n_new[s] = (tag_q.first ? '0 : acc_n_q[s])
                     + ERR_W'(bit_count8(pair[15-s -: 8] ^ want));
      acc_i_new[s] = (tag_q.first ? '0 : acc_i_q[s])
                     + ERR_W'(bit_count8(pair[15-s -: 8] ^ want ^ INV_MASK));
      hit_mask[s]  = (acc_n_new[s] <= max_sync_errors_i) ||
                     (acc_i_new[s] <= max_sync_errors_i);
      hit_inv[s]   = (acc_n_new[s] > max_sync_errors_i);
    end
  end

  // Notice emitter: lowest pending offset first.
  assign res_space   = !res_full_i;
  assign em_busy     = (em_mask_q != '0);
  assign em_one      = em_busy && ((em_mask_q & (em_mask_q - LANES'(1))) == '0);
  assign em_emit     = em_busy && res_space;
  assign em_can_load = !em_busy || (em_one && res_space);

  always_comb begin
    em_sel   = '0;
    em_found = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if (!em_found && em_mask_q[i]) begin
        em_sel   = SHIFT_W'(i);
        em_found = 1'b1;
      end
    end
  end

  // Data stage acceptance; a read answer waits until earlier notices are out.
  always_comb begin
    if (tag_q.is_read) begin
      d_take = !em_busy && res_space;
    end else begin
      d_take = !tag_q.last_pkt || em_can_load;
    end
  end

  assign stall     = tag_vld_q && !d_take;
  assign load_mask = tag_vld_q && !tag_q.is_read && tag_q.last_pkt && d_take;
  assign read_out  = tag_vld_q && tag_q.is_read && d_take;

  always_comb begin
    em_mask_d = em_mask_q;
    em_inv_d  = em_inv_q;
    if (em_emit) begin
      em_mask_d[em_sel] = 1'b0;
    end
    if (load_mask) begin
      em_mask_d = hit_mask;
      em_inv_d  = hit_inv;
    end
  end

  // Result transaction assembly.
  assign pair_shl = pair << tag_q.shift;

  always_comb begin
    res_o       = '0;
    res_write_o = em_emit || read_out;
    if (em_emit) begin
      res_o.bit_shift = em_sel;
      res_o.inverted  = em_inv_q[em_sel];
      res_o.last      = em_one;
    end else begin
      res_o.is_read_data = 1'b1;
      res_o.bit_shift    = tag_q.shift;
      res_o.inverted     = tag_q.inv;
      res_o.last         = 1'b1;
      if (tag_q.in_range) begin
        res_o.frame_byte = tag_q.inv ? (pair_shl[15:8] ^ INV_MASK) : pair_shl[15:8];
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_busy_q <= 1'b0;
      iss_cnt_q  <= '0;
      iss_pos_q  <= '0;
      tag_vld_q  <= 1'b0;
      em_mask_q  <= '0;
      em_inv_q   <= '0;
    end else begin
      iss_busy_q <= iss_busy_d;
      iss_cnt_q  <= iss_cnt_d;
      iss_pos_q  <= iss_pos_d;
      tag_vld_q  <= tag_vld_d;
      em_mask_q  <= em_mask_d;
      em_inv_q   <= em_inv_d;
    end
  end

  // Tag and running error counts.
  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    if (tag_vld_q && !tag_q.is_read && d_take) begin
      for (int s = 0; s < LANES; s++) begin
        acc_n_q[s] <= acc_n_new[s];
        acc_i_q[s] <= acc_i_new[s];
      end
    end
  end

endmodule

[dv/tb_ts_frame_sync_detector.sv]
// Testbench for ts_frame_sync_detector: directed and random transport stream traffic,
// with every result checked field by field against a bit-accurate sync search model.
// Depends on tsfs_pkg and the ts_frame_sync_detector RTL.
`timescale 1ns / 100ps

module tb_ts_frame_sync_detector;
  import tsfs_pkg::*;

  localparam int unsigned PKT_LEN       = PACKET_BYTES_DEF;
  localparam int unsigned PKT_COUNT     = PACKETS_PER_FRAME_DEF;
  localparam int unsigned FRAME_LEN     = PKT_LEN * PKT_COUNT;
  localparam int unsigned WINDOW_LEN    = FRAME_LEN + 1;
  localparam int unsigned IDX_TOP       = (1 << IDX_W) - 1;
  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned MAX_PRINTS    = 100;

  // Configuration addresses: the register index sits above the byte offset.
  localparam logic [2:0] ADDR_MAX_SYNC_ERRORS = {REG_MAX_SYNC_ERRORS, 2'b00};
  localparam logic [2:0] ADDR_SPARE           = 3'b100;

  // One input transaction as it is put on the ports.
  typedef struct packed {
    op_e                op;
    logic [7:0]         data_byte;
    logic [IDX_W-1:0]   read_index;
    logic [SHIFT_W-1:0] read_shift;
    logic               read_inverted;
  } ts_cmd_t;

  localparam int unsigned CMD_W = $bits(ts_cmd_t);

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [2:0]         paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               push    = 1'b0;
  logic               full;
  logic               operation_i;
  logic [7:0]         data_byte_i;
  logic [IDX_W-1:0]   read_index_i;
  logic [SHIFT_W-1:0] read_shift_i;
  logic               read_inverted_i;
  logic               empty;
  logic               pop     = 1'b0;
  logic               is_read_data_o;
  logic [SHIFT_W-1:0] bit_shift_o;
  logic               inverted_o;
  logic [7:0]         frame_byte_o;
  logic               last_o;

  ts_cmd_t cmd_on_port = '0;

  assign operation_i     = cmd_on_port.op;
  assign data_byte_i     = cmd_on_port.data_byte;
  assign read_index_i    = cmd_on_port.read_index;
  assign read_shift_i    = cmd_on_port.read_shift;
  assign read_inverted_i = cmd_on_port.read_inverted;

  ts_frame_sync_detector dut (.*);

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state, stimulus and expectation stores.
  logic [7:0]       model_window [WINDOW_LEN];
  logic [ERR_W-1:0] model_err_limit;
  ts_cmd_t          stream_cmds[$];
  res_t             predicted_answers[$];

  bit          idling_on     = 1'b0;
  bit          push_taken    = 1'b0;
  int unsigned push_gap      = 0;
  int unsigned pop_stall     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen  = 0;

  // Gap length for either side: none while idling is off, else mostly none or short, now and then long.
  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 7);
    return $urandom_range(12, 48);
  endfunction

  function automatic ts_cmd_t push_cmd(input logic [7:0] b);
    ts_cmd_t c;
    c = ts_cmd_t'(CMD_W'($urandom));
    c.op = OP_PUSH;
    c.data_byte = b;
    return c;
  endfunction

  function automatic ts_cmd_t read_cmd(input int unsigned idx, input logic [SHIFT_W-1:0] s,
                                       input logic inv);
    ts_cmd_t c;
    c.op = OP_READ;
    c.data_byte = 8'($urandom);
    c.read_index = IDX_W'(idx);
    c.read_shift = s;
    c.read_inverted = inv;
    return c;
  endfunction

  // Reads land mostly inside the frame, sometimes past its end.
  function automatic ts_cmd_t random_read();
    int unsigned idx;
    if ($urandom_range(0, 9) == 0) idx = $urandom_range(FRAME_LEN, IDX_TOP);
    else idx = $urandom_range(0, FRAME_LEN - 1);
    return read_cmd(idx, SHIFT_W'($urandom), 1'($urandom));
  endfunction

  function automatic ts_cmd_t random_cmd();
    if ($urandom_range(0, 3) == 0) return random_read();
    return push_cmd(8'($urandom));
  endfunction

  // Window byte at pos seen through a bit offset of s.
  function automatic logic [7:0] realigned(input int unsigned pos, input logic [SHIFT_W-1:0] s);
    logic [15:0] pair;
    pair = {model_window[pos], model_window[pos + 1]};
    return pair[15 - int'(s) -: 8];
  endfunction

  // Applies one accepted transaction to the model and queues the results it causes.
  task automatic advance_sync_model(input ts_cmd_t c);
    res_t        r;
    res_t        notices[$];
    logic [7:0]  b;
    logic [7:0]  want;
    int unsigned err_nor;
    int unsigned err_inv;
    if (c.op == OP_READ) begin
      r = '0;
      r.is_read_data = 1'b1;
      r.bit_shift = c.read_shift;
      r.inverted = c.read_inverted;
      r.last = 1'b1;
      if (c.read_index < FRAME_LEN) begin
        r.frame_byte = realigned(32'(c.read_index), c.read_shift) ^
                       (c.read_inverted ? INV_MASK : 8'h00);
      end
      predicted_answers.push_back(r);
    end else begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) model_window[i] = model_window[i + 1];
      model_window[WINDOW_LEN - 1] = c.data_byte;
      // Score every offset against both polarities; normal polarity wins a tie.
      for (int s = 0; s < LANES; s++) begin
        err_nor = 0;
        err_inv = 0;
        for (int p = 0; p < PKT_COUNT; p++) begin
          b = realigned(p * PKT_LEN, SHIFT_W'(s));
          want = (p == 0) ? SYNC_FIRST : SYNC_REST;
          err_nor += $countones(b ^ want);
          err_inv += $countones(b ^ want ^ INV_MASK);
        end
        if (err_nor <= model_err_limit || err_inv <= model_err_limit) begin
          r = '0;
          r.bit_shift = SHIFT_W'(s);
          r.inverted = (err_nor > model_err_limit);
          notices.push_back(r);
        end
      end
      if (notices.size() > 0) begin
        r = notices[notices.size() - 1];
        r.last = 1'b1;
        notices[notices.size() - 1] = r;
      end
      foreach (notices[i]) predicted_answers.push_back(notices[i]);
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got, want));
    end
  endtask

  // Input driver: record accepted transactions at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      advance_sync_model(cmd_on_port);
      push_taken = 1'b1;
    end
  end

  // Input driver: present the next transaction at the falling edge after a random gap.
  always @(negedge clk_i) begin
    if (!push || push_taken) begin
      push_taken = 1'b0;
      if (push_gap > 0) begin
        push <= 1'b0;
        push_gap--;
      end else if (rst_ni && stream_cmds.size() > 0) begin
        cmd_on_port <= stream_cmds.pop_front();
        push <= 1'b1;
        push_gap = random_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result side: pop with random stalls.
  always @(negedge clk_i) begin
    if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 7) == 0) pop_stall = random_gap();
    end
  end

  // Monitor: compare each popped result with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (predicted_answers.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing predicted", results_seen));
      end else begin
        want = predicted_answers.pop_front();
        compare_field("is_read_data", 8'(is_read_data_o), 8'(want.is_read_data));
        compare_field("bit_shift", 8'(bit_shift_o), 8'(want.bit_shift));
        compare_field("inverted", 8'(inverted_o), 8'(want.inverted));
        compare_field("frame_byte", frame_byte_o, want.frame_byte);
        compare_field("last", 8'(last_o), 8'(want.last));
      end
    end
  end

  // Watchdog: too long without any accepted transaction ends the run.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ts_frame_sync_detector regression: fail");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
    logic [31:0] got;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      note_mismatch($sformatf("register read at %0h: got %0h, want %0h", addr, got, want));
    end
  endtask

  // Wait until every queued transaction is in and answered, then let the pipeline empty.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (stream_cmds.size() != 0 || push || predicted_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_err_limit(input logic [ERR_W-1:0] limit);
    wait_drained();
    apb_write(ADDR_MAX_SYNC_ERRORS, 32'(limit));
    model_err_limit = limit;
    apb_read_check(ADDR_MAX_SYNC_ERRORS, 32'(limit));
  endtask

  initial begin : stimulus
    foreach (model_window[i]) model_window[i] = '0;
    model_err_limit = MAX_ERR_RESET;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty window at the reset limit, reads at and past the frame edges.
    stream_cmds.push_back(read_cmd(0, 3'd0, 1'b0));
    stream_cmds.push_back(read_cmd(FRAME_LEN - 1, 3'd7, 1'b1));
    stream_cmds.push_back(read_cmd(FRAME_LEN, 3'd5, 1'b1));
    stream_cmds.push_back(read_cmd(IDX_TOP, 3'd7, 1'b1));
    stream_cmds.push_back(push_cmd(8'hFF));
    stream_cmds.push_back(push_cmd(8'h00));
    stream_cmds.push_back(push_cmd(SYNC_FIRST));
    stream_cmds.push_back(push_cmd(SYNC_REST));
    stream_cmds.push_back(read_cmd(FRAME_LEN - 1, 3'd3, 1'b0));
    stream_cmds.push_back(read_cmd(FRAME_LEN - 2, 3'd0, 1'b1));

    // Widest limit: every offset matches, eight notices per push.
    set_err_limit(7'd64);
    stream_cmds.push_back(push_cmd(8'hAA));
    stream_cmds.push_back(push_cmd(8'h55));
    stream_cmds.push_back(read_cmd(FRAME_LEN - 3, 3'd1, 1'b0));
    stream_cmds.push_back(push_cmd(8'h0F));

    // A write to an unmapped register must leave the limit alone.
    wait_drained();
    apb_write(ADDR_SPARE, 32'h0);
    apb_read_check(ADDR_MAX_SYNC_ERRORS, 32'd64);
    stream_cmds.push_back(push_cmd(8'hF0));
    stream_cmds.push_back(push_cmd(8'h3C));

    // Zero sync bytes score 32 against both patterns: both match, normal must win.
    set_err_limit(7'd32);
    stream_cmds.push_back(push_cmd(8'h81));
    stream_cmds.push_back(push_cmd(8'h7E));

    // Push random bytes into the window at a limit that zero sync bytes miss.
    set_err_limit(7'd30);
    idling_on = 1'b1;
    repeat (120) stream_cmds.push_back(push_cmd(8'($urandom)));

    // Tightest limit, no idling.
    set_err_limit(7'd0);
    idling_on = 1'b0;
    repeat (20) stream_cmds.push_back(random_cmd());

    // Near-open limit with stalls, so the result queue fills.
    set_err_limit(7'd63);
    idling_on = 1'b1;
    repeat (15) stream_cmds.push_back(random_cmd());

    // Random traffic near the decision point; once data reaches the last sync byte,
    // both polarities show up.
    set_err_limit(7'd33);
    idling_on = 1'b1;
    repeat (100) stream_cmds.push_back(random_cmd());

    wait_drained();
    if (mismatch_count == 0) begin
      $display("ts_frame_sync_detector regression: pass");
    end else begin
      $display("ts_frame_sync_detector regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tsfs_pkg.sv
sv/tsfs_front.sv
sv/tsfs_window.sv
sv/tsfs_res_fifo.sv
sv/tsfs_back.sv
sv/ts_frame_sync_detector.sv
dv/tb_ts_frame_sync_detector.sv
